// ===== sv/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the step loss monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_STEPS = 33;
  localparam int MUL_STEPS = 9;
  localparam int CNT_W     = 6;
  localparam int FACTOR_W  = 9;
  localparam int ERR_FS_W  = 30;
  localparam int ACC_W     = 40;
  localparam int ERR_W     = 37;
  localparam int CORR_W    = 12;

  localparam logic [DIV_DEN_W-1:0] ENC_DEN      = 10'd360;
  localparam logic [DIV_NUM_W:0]   ENC_HALF     = 34'd180;
  localparam logic [FACTOR_W-1:0]  MIN_FACTOR   = 9'd16;
  localparam logic signed [ACC_W-1:0] ERR_MAX   = 40'sd68719476735;
  localparam logic signed [ACC_W-1:0] ERR_MIN   = -40'sd68719476736;
  localparam logic signed [ERR_FS_W-1:0] CORR_HI = 30'sd4;
  localparam logic signed [ERR_FS_W-1:0] CORR_LO = -30'sd4;

  localparam logic [2:0] REG_FACTOR  = 3'd0;
  localparam logic [2:0] REG_HOLD    = 3'd1;
  localparam logic [2:0] REG_FAST    = 3'd2;
  localparam logic [2:0] REG_LIMITS  = 3'd3;
  localparam logic [2:0] REG_CONFIRM = 3'd4;
  localparam logic [2:0] REG_RECOVER = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef enum logic [1:0] {
    SPEED_HOLD = 2'd0,
    SPEED_RUN  = 2'd1,
    SPEED_FAST = 2'd2
  } band_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/slm_div.sv =====
// ----------------------------------------------------------------------------
// slm_div
// Bit-serial restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_div
  import slm_pkg::*;
(
  input  wire logic                 clk,
  input  wire div_ctrl_t            ctrl,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic      [DIV_NUM_W-1:0] quo
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (ctrl.step) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== sv/step_loss_monitor.sv =====
// ----------------------------------------------------------------------------
// step_loss_monitor
// Step loss detection with speed bands, confirm time and recovery timeout.
// ----------------------------------------------------------------------------
// One item per monitor tick passes, from acceptance to result, through the
// two bit-serial rounding dividers (encoder angle by 180 and commanded
// position by the microstep factor, run side by side), a step that forms the
// full-step error and picks the band, the serial multiplier by the microstep
// factor, and an update step. The input is taken again in the cycle after
// the update; a stalled result holds only the update state. Registers sit at
// byte address 8*i, 64-bit data.
// ----------------------------------------------------------------------------
`default_nettype none

module step_loss_monitor
  import slm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // time_ms[31:0], commanded_position[63:32], speed_estimate[95:64],
  // encoder_angle[127:96]
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // position_error[36:0], speed_band[38:37], over_limit[39], loss_active[40],
  // recovery_running[41], fault_request[42], suggested_correction[54:43],
  // zero[55]
  output logic [55:0]       m_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // configuration
  logic [FACTOR_W-1:0] microstep_factor;
  logic [31:0]         hold_speed_limit;
  logic [31:0]         fast_speed_limit;
  logic [47:0]         band_error_limits;
  logic [47:0]         band_confirm_times;
  logic [31:0]         recovery_timeout;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      microstep_factor   <= 9'd16;
      hold_speed_limit   <= '0;
      fast_speed_limit   <= '1;
      band_error_limits  <= '0;
      band_confirm_times <= '0;
      recovery_timeout   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_FACTOR:  microstep_factor   <= pwdata[FACTOR_W-1:0];
        REG_HOLD:    hold_speed_limit   <= pwdata[31:0];
        REG_FAST:    fast_speed_limit   <= pwdata[31:0];
        REG_LIMITS:  band_error_limits  <= pwdata[47:0];
        REG_CONFIRM: band_confirm_times <= pwdata[47:0];
        REG_RECOVER: recovery_timeout   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FACTOR:  prdata = {55'd0, microstep_factor};
      REG_HOLD:    prdata = {32'd0, hold_speed_limit};
      REG_FAST:    prdata = {32'd0, fast_speed_limit};
      REG_LIMITS:  prdata = {16'd0, band_error_limits};
      REG_CONFIRM: prdata = {16'd0, band_confirm_times};
      REG_RECOVER: prdata = {32'd0, recovery_timeout};
      default:     prdata = '0;
    endcase
  end

  logic [FACTOR_W-1:0] m_eff;
  assign m_eff = (microstep_factor < MIN_FACTOR) ? MIN_FACTOR : microstep_factor;

  // control
  state_t     state, state_next;
  div_ctrl_t  div_ctrl;
  logic       err_load;
  logic       mul_step;
  logic       upd_fire;
  logic       out_free;
  logic [CNT_W-1:0] cnt;
  logic       div_last;
  logic       mul_last;

  assign out_free = !m_tvalid || m_tready;
  assign div_last = cnt == CNT_W'(DIV_STEPS - 1);
  assign mul_last = cnt == CNT_W'(MUL_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL:  if (mul_last) state_next = ST_UPD;
      ST_UPD:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    err_load      = 1'b0;
    mul_step      = 1'b0;
    upd_fire      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        div_ctrl.load = s_tvalid;
      end
      ST_DIV:  div_ctrl.step = 1'b1;
      ST_ERR:  err_load = 1'b1;
      ST_MUL:  mul_step = 1'b1;
      ST_UPD:  upd_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (div_ctrl.step) begin
      cnt <= div_last ? '0 : cnt + 1'b1;
    end else if (mul_step) begin
      cnt <= mul_last ? '0 : cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // input capture and divider operands
  logic [31:0]        in_time;
  logic signed [31:0] in_pos;
  logic signed [31:0] in_spd;
  logic signed [31:0] in_enc;
  logic [31:0]        now;
  logic signed [31:0] spd;
  logic               pos_neg;
  logic               enc_neg;

  assign in_time = s_tdata[31:0];
  assign in_pos  = s_tdata[63:32];
  assign in_spd  = s_tdata[95:64];
  assign in_enc  = s_tdata[127:96];

  always_ff @(posedge clk) begin
    if (div_ctrl.load) begin
      now     <= in_time;
      spd     <= in_spd;
      pos_neg <= in_pos[31];
      enc_neg <= in_enc[31];
    end
  end

  logic [DIV_NUM_W:0]     enc2, pos2, enc_num, pos_num, m_half;
  logic [DIV_DEN_W-1:0]   pos_den;
  logic [DIV_NUM_W-1:0]   q_enc, q_pos;

  assign enc2    = {in_enc[31], in_enc, 1'b0};
  assign pos2    = {in_pos[31], in_pos, 1'b0};
  assign m_half  = {{(DIV_NUM_W + 1 - FACTOR_W){1'b0}}, m_eff};
  assign enc_num = in_enc[31] ? (ENC_HALF - enc2) : (enc2 + ENC_HALF);
  assign pos_num = in_pos[31] ? (m_half - pos2) : (pos2 + m_half);
  assign pos_den = {m_eff, 1'b0};

  slm_div u_div_enc (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (enc_num[DIV_NUM_W-1:0]),
    .den  (ENC_DEN),
    .quo  (q_enc)
  );

  slm_div u_div_pos (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (pos_num[DIV_NUM_W-1:0]),
    .den  (pos_den),
    .quo  (q_pos)
  );

  // full-step error, band selection
  logic signed [ERR_FS_W-1:0] fs_enc, fs_pos, err_fs_c, err_fs;
  logic [32:0]                spd_x, aspd;
  band_t                      band_c, band;
  logic [15:0]                thr_c, thr;
  logic [15:0]                conf_c, conf;

  assign fs_enc   = enc_neg ? -$signed(q_enc[ERR_FS_W-1:0]) : $signed(q_enc[ERR_FS_W-1:0]);
  assign fs_pos   = pos_neg ? -$signed(q_pos[ERR_FS_W-1:0]) : $signed(q_pos[ERR_FS_W-1:0]);
  assign err_fs_c = fs_enc - fs_pos;

  assign spd_x = {spd[31], spd};
  assign aspd  = spd[31] ? (33'd0 - spd_x) : spd_x;

  always_comb begin
    if (aspd <= {1'b0, hold_speed_limit}) begin
      band_c = SPEED_HOLD;
    end else if (aspd >= {1'b0, fast_speed_limit}) begin
      band_c = SPEED_FAST;
    end else begin
      band_c = SPEED_RUN;
    end
    unique case (band_c)
      SPEED_HOLD: begin
        thr_c  = band_error_limits[15:0];
        conf_c = band_confirm_times[15:0];
      end
      SPEED_RUN: begin
        thr_c  = band_error_limits[31:16];
        conf_c = band_confirm_times[31:16];
      end
      default: begin
        thr_c  = band_error_limits[47:32];
        conf_c = band_confirm_times[47:32];
      end
    endcase
  end

  // serial multiply by the microstep factor
  logic signed [ACC_W-1:0] mcand, acc;
  logic [FACTOR_W-1:0]     mplier;

  always_ff @(posedge clk) begin
    if (err_load) begin
      err_fs <= err_fs_c;
      band   <= band_c;
      thr    <= thr_c;
      conf   <= conf_c;
      mcand  <= ACC_W'(err_fs_c);
      mplier <= m_eff;
      acc    <= '0;
    end else if (mul_step) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  // tracking state update
  logic [31:0] over_since, recovery_start;
  logic        over_valid, loss_flag, recovery_flag, fault_flag;
  logic [31:0] over_since_next, recovery_start_next;
  logic        over_valid_next, loss_flag_next, recovery_flag_next, fault_flag_next;
  logic [ERR_FS_W-1:0] aerr;
  logic        over;

  assign aerr = err_fs[ERR_FS_W-1] ? ERR_FS_W'(-err_fs) : ERR_FS_W'(err_fs);
  assign over = aerr > {{(ERR_FS_W - 16){1'b0}}, thr};

  always_comb begin
    over_since_next     = over_since;
    over_valid_next     = over_valid;
    recovery_start_next = recovery_start;
    loss_flag_next      = loss_flag;
    recovery_flag_next  = recovery_flag;
    fault_flag_next     = fault_flag;
    if (over) begin
      if (!over_valid) begin
        over_valid_next = 1'b1;
        over_since_next = now;
      end
      if (!loss_flag && ((now - over_since_next) >= {16'd0, conf})) begin
        loss_flag_next      = 1'b1;
        recovery_flag_next  = 1'b1;
        recovery_start_next = now;
      end
    end else begin
      over_valid_next = 1'b0;
      over_since_next = '0;
      if (loss_flag) begin
        loss_flag_next      = 1'b0;
        recovery_flag_next  = 1'b0;
        recovery_start_next = '0;
      end
    end
    if (recovery_flag_next && ((now - recovery_start_next) >= recovery_timeout)) begin
      fault_flag_next    = 1'b1;
      recovery_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over_since     <= '0;
      over_valid     <= 1'b0;
      recovery_start <= '0;
      loss_flag      <= 1'b0;
      recovery_flag  <= 1'b0;
      fault_flag     <= 1'b0;
    end else if (upd_fire) begin
      over_since     <= over_since_next;
      over_valid     <= over_valid_next;
      recovery_start <= recovery_start_next;
      loss_flag      <= loss_flag_next;
      recovery_flag  <= recovery_flag_next;
      fault_flag     <= fault_flag_next;
    end
  end

  // result
  logic [ERR_W-1:0]  err_sat;
  logic signed [3:0] c4, negc;
  logic signed [13:0] corr_full;

  always_comb begin
    if (acc > ERR_MAX) begin
      err_sat = ERR_MAX[ERR_W-1:0];
    end else if (acc < ERR_MIN) begin
      err_sat = ERR_MIN[ERR_W-1:0];
    end else begin
      err_sat = acc[ERR_W-1:0];
    end
    if (err_fs > CORR_HI) begin
      c4 = CORR_HI[3:0];
    end else if (err_fs < CORR_LO) begin
      c4 = CORR_LO[3:0];
    end else begin
      c4 = err_fs[3:0];
    end
  end

  assign negc      = -c4;
  assign corr_full = negc * $signed({1'b0, m_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      m_tdata <= {1'b0, corr_full[CORR_W-1:0], fault_flag_next, recovery_flag_next,
                  loss_flag_next, over, band, err_sat};
    end
  end

endmodule

`default_nettype wire
